[rtl/stream_request_table_top_defines.svh]
// ----------------------------------------------------------------------------
// Stream request table assertion macros
// Concurrent checks on the top level, clocked by clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef STREAM_REQUEST_TABLE_TOP_DEFINES_SVH
`define STREAM_REQUEST_TABLE_TOP_DEFINES_SVH

// Check post in the same cycle as pre.
`define SRT_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Check post in the cycle after pre.
`define SRT_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[rtl/srt_pkg.sv]
// ----------------------------------------------------------------------------
// Stream request table package
// Field widths, request and status codes, and the stream entry layout.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int MAX_STREAMS_DEF = 16;
  localparam int MAX_SINKS_DEF   = 8;

  localparam int NODE_W   = 16;
  localparam int SID_W    = 3;
  localparam int TIME_W   = 16;
  localparam int MISSED_W = 8;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 4;
  localparam int HELD_W   = 5;

  localparam logic [SID_W-1:0] TOP_STREAM_ID = 3'd2;

  localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REPLACE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SINK    = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_IGNORED          = 4'd0;
  localparam logic [STATUS_W-1:0] STAT_ADDED            = 4'd1;
  localparam logic [STATUS_W-1:0] STAT_DUPLICATE        = 4'd2;
  localparam logic [STATUS_W-1:0] STAT_NO_SPACE         = 4'd3;
  localparam logic [STATUS_W-1:0] STAT_REPLACED         = 4'd4;
  localparam logic [STATUS_W-1:0] STAT_REPLACED_NO_SPACE = 4'd5;
  localparam logic [STATUS_W-1:0] STAT_DELETED          = 4'd6;
  localparam logic [STATUS_W-1:0] STAT_DEL_NOT_FOUND    = 4'd7;
  localparam logic [STATUS_W-1:0] STAT_SINK_ADDED       = 4'd8;
  localparam logic [STATUS_W-1:0] STAT_SINK_DUP         = 4'd9;
  localparam logic [STATUS_W-1:0] STAT_SINK_FULL        = 4'd10;

  typedef struct packed {
    logic [NODE_W-1:0]   node;
    logic [SID_W-1:0]    stream;
    logic [TIME_W-1:0]   interval;
    logic [TIME_W-1:0]   last_slot;
    logic [TIME_W-1:0]   ready_time;
    logic [MISSED_W-1:0] missed;
  } entry_t;

endpackage

[rtl/stream_request_table_top.sv]
// ----------------------------------------------------------------------------
// Stream request table
// Keeps a table of periodic streams and a table of sink nodes and answers one
// request per transaction with a status and the number of streams held.
// ----------------------------------------------------------------------------
// A request is answered after one pass through the entry memory (the sink
// memory for a sink registration), one read per cycle, followed by one
// write-back step. A request that is ignored (stream id above 2 or own node)
// skips the pass and goes straight to the write-back step. The next request
// is taken while a result waits in the output register.
`include "stream_request_table_top_defines.svh"

module stream_request_table_top #(
  parameter int MAX_STREAMS = srt_pkg::MAX_STREAMS_DEF,
  parameter int MAX_SINKS   = srt_pkg::MAX_SINKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srt_pkg::NODE_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [srt_pkg::MODE_W-1:0]    mode,
  input  logic [srt_pkg::NODE_W-1:0]    source_node,
  input  logic [srt_pkg::SID_W-1:0]     stream_number,
  input  logic [srt_pkg::TIME_W-1:0]    interval,
  input  logic [srt_pkg::TIME_W-1:0]    start_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [srt_pkg::STATUS_W-1:0]  status,
  output logic [srt_pkg::HELD_W-1:0]    streams_held
);

  localparam int EIDX_W   = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int SIDX_W   = (MAX_SINKS > 1) ? $clog2(MAX_SINKS) : 1;
  localparam int CNT_W    = $clog2(MAX_STREAMS + 1);
  localparam int SCAN_MAX = (MAX_STREAMS > MAX_SINKS) ? MAX_STREAMS : MAX_SINKS;
  localparam int SCAN_W   = $clog2(SCAN_MAX + 1);

  localparam logic [SCAN_W-1:0] STREAM_END = SCAN_W'(MAX_STREAMS);
  localparam logic [SCAN_W-1:0] SINK_END   = SCAN_W'(MAX_SINKS);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state;

  logic [srt_pkg::NODE_W-1:0] own_node_id;

  logic [srt_pkg::MODE_W-1:0] req_mode;
  logic [srt_pkg::NODE_W-1:0] req_node;
  logic [srt_pkg::SID_W-1:0]  req_stream;
  logic [srt_pkg::TIME_W-1:0] req_interval;
  logic [srt_pkg::TIME_W-1:0] req_start;
  logic                       req_pass;
  logic                       req_is_sink;

  srt_pkg::entry_t            entry_mem [MAX_STREAMS];
  srt_pkg::entry_t            entry_rd;
  logic [EIDX_W-1:0]          entry_rd_addr;
  logic                       entry_we;
  logic [EIDX_W-1:0]          entry_waddr;
  srt_pkg::entry_t            entry_wdata;
  srt_pkg::entry_t            new_entry;
  srt_pkg::entry_t            dup_entry;
  logic [MAX_STREAMS-1:0]     entry_valid;
  logic [MAX_STREAMS-1:0]     entry_valid_next;
  logic                       entry_set;
  logic                       entry_clr;

  logic [srt_pkg::NODE_W-1:0] sink_mem [MAX_SINKS];
  logic [srt_pkg::NODE_W-1:0] sink_rd;
  logic [SIDX_W-1:0]          sink_rd_addr;
  logic                       sink_we;
  logic [MAX_SINKS-1:0]       sink_valid;

  logic [CNT_W-1:0]           stream_count;
  logic [CNT_W-1:0]           stream_count_next;

  logic [SCAN_W-1:0]          scan_cnt;
  logic [SCAN_W-1:0]          scan_end;
  logic                       scan_issue;
  logic                       rd_pending;
  logic [SCAN_W-1:0]          rd_idx;
  logic [EIDX_W-1:0]          rd_eidx;
  logic [SIDX_W-1:0]          rd_sidx;
  logic                       entry_hit;
  logic                       entry_free;
  logic                       sink_hit;
  logic                       sink_free;

  logic                       found;
  logic [EIDX_W-1:0]          found_idx;
  srt_pkg::entry_t            found_word;
  logic                       free_found;
  logic [EIDX_W-1:0]          free_idx;
  logic [SIDX_W-1:0]          sink_free_idx;
  logic                       sink_dup;

  logic                       update_go;
  logic [srt_pkg::STATUS_W-1:0] res_status;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      own_node_id <= '0;
    end else if (cfg_valid && cfg_ready) begin
      own_node_id <= cfg_data;
    end
  end

  assign req_is_sink   = (req_mode == srt_pkg::MODE_SINK);
  assign scan_end      = req_is_sink ? SINK_END : STREAM_END;
  assign scan_issue    = (state == ST_SCAN) && (scan_cnt != scan_end);
  assign entry_rd_addr = scan_cnt[EIDX_W-1:0];
  assign sink_rd_addr  = scan_cnt[SIDX_W-1:0];
  assign rd_eidx       = rd_idx[EIDX_W-1:0];
  assign rd_sidx       = rd_idx[SIDX_W-1:0];

  assign entry_hit  = rd_pending && entry_valid[rd_eidx] && (entry_rd.node == req_node) &&
                      (entry_rd.stream == req_stream);
  assign entry_free = rd_pending && (!entry_valid[rd_eidx] ||
                      ((req_mode == srt_pkg::MODE_REPLACE) && entry_hit));
  assign sink_hit   = rd_pending && sink_valid[rd_sidx] && (sink_rd == req_node);
  assign sink_free  = rd_pending && !sink_valid[rd_sidx];

  always_ff @(posedge clk) begin
    entry_rd <= entry_mem[entry_rd_addr];
    if (entry_we) begin
      entry_mem[entry_waddr] <= entry_wdata;
    end
  end

  always_ff @(posedge clk) begin
    sink_rd <= sink_mem[sink_rd_addr];
    if (sink_we) begin
      sink_mem[sink_free_idx] <= req_node;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_pending <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          rd_pending <= 1'b0;
          if (in_valid) begin
            state <= ((stream_number <= srt_pkg::TOP_STREAM_ID) &&
                      (source_node != own_node_id)) ? ST_SCAN : ST_UPDATE;
          end
        end
        ST_SCAN: begin
          rd_pending <= scan_issue;
          if (!scan_issue && !rd_pending) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (update_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      req_mode     <= mode;
      req_node     <= source_node;
      req_stream   <= stream_number;
      req_interval <= interval;
      req_start    <= start_time;
      req_pass     <= (stream_number <= srt_pkg::TOP_STREAM_ID) &&
                      (source_node != own_node_id);
      found        <= 1'b0;
      free_found   <= 1'b0;
      sink_dup     <= 1'b0;
      scan_cnt     <= '0;
    end else if (state == ST_SCAN) begin
      rd_idx <= scan_cnt;
      if (scan_issue) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (req_is_sink) begin
        if (sink_hit) begin
          sink_dup <= 1'b1;
        end
        if (sink_free && !free_found) begin
          free_found    <= 1'b1;
          sink_free_idx <= rd_sidx;
        end
      end else begin
        if (entry_hit && !found) begin
          found      <= 1'b1;
          found_idx  <= rd_eidx;
          found_word <= entry_rd;
        end
        if (entry_free && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= rd_eidx;
        end
      end
    end
  end

  assign update_go = (state == ST_UPDATE) && (!out_valid || out_ready);

  always_comb begin
    new_entry.node       = req_node;
    new_entry.stream     = req_stream;
    new_entry.interval   = req_interval;
    new_entry.last_slot  = req_start - req_interval;
    new_entry.ready_time = req_start;
    new_entry.missed     = '0;
    dup_entry            = found_word;
    dup_entry.missed     = '0;
  end

  always_comb begin
    entry_we    = 1'b0;
    entry_waddr = free_idx;
    entry_wdata = new_entry;
    entry_set   = 1'b0;
    entry_clr   = 1'b0;
    sink_we     = 1'b0;
    res_status  = srt_pkg::STAT_IGNORED;
    if (req_pass) begin
      unique case (req_mode)
        srt_pkg::MODE_ADD: begin
          if (found) begin
            entry_we    = 1'b1;
            entry_waddr = found_idx;
            entry_wdata = dup_entry;
            res_status  = srt_pkg::STAT_DUPLICATE;
          end else if (free_found) begin
            entry_we   = 1'b1;
            entry_set  = 1'b1;
            res_status = srt_pkg::STAT_ADDED;
          end else begin
            res_status = srt_pkg::STAT_NO_SPACE;
          end
        end
        srt_pkg::MODE_REPLACE: begin
          entry_clr = found;
          if (free_found) begin
            entry_we   = 1'b1;
            entry_set  = 1'b1;
            res_status = srt_pkg::STAT_REPLACED;
          end else begin
            res_status = srt_pkg::STAT_REPLACED_NO_SPACE;
          end
        end
        srt_pkg::MODE_DELETE: begin
          entry_clr  = found;
          res_status = found ? srt_pkg::STAT_DELETED : srt_pkg::STAT_DEL_NOT_FOUND;
        end
        srt_pkg::MODE_SINK: begin
          if (sink_dup) begin
            res_status = srt_pkg::STAT_SINK_DUP;
          end else if (free_found) begin
            sink_we    = 1'b1;
            res_status = srt_pkg::STAT_SINK_ADDED;
          end else begin
            res_status = srt_pkg::STAT_SINK_FULL;
          end
        end
        default: begin
          res_status = srt_pkg::STAT_IGNORED;
        end
      endcase
    end
    entry_we  = entry_we && update_go;
    entry_set = entry_set && update_go;
    entry_clr = entry_clr && update_go;
    sink_we   = sink_we && update_go;
  end

  assign stream_count_next = stream_count + CNT_W'(entry_set) - CNT_W'(entry_clr);

  always_comb begin
    entry_valid_next = entry_valid;
    if (entry_clr) begin
      entry_valid_next[found_idx] = 1'b0;
    end
    if (entry_set) begin
      entry_valid_next[free_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      sink_valid   <= '0;
      stream_count <= '0;
    end else begin
      stream_count <= stream_count_next;
      entry_valid  <= entry_valid_next;
      if (sink_we) begin
        sink_valid[sink_free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (update_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (update_go) begin
      status       <= res_status;
      streams_held <= srt_pkg::HELD_W'(stream_count_next);
    end
  end

  `SRT_ASSERT_NOW(a_count_tracks_valid, 1'b1, $countones(entry_valid) == int'(stream_count), "stream count out of step with valid bits")
  `SRT_ASSERT_NOW(a_replace_has_slot, (state == ST_UPDATE) && req_pass && (req_mode == srt_pkg::MODE_REPLACE) && found, free_found, "replace found an entry but no free slot")
  `SRT_ASSERT_NEXT(a_update_completes, (state == ST_UPDATE) && !out_valid, out_valid && (state == ST_IDLE), "update step stalled with an empty output register")

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// Stream request table testbench
// Drives requests and own-node writes through valid/ready channels with random
// gaps and stalls. A directed table covers filtering, add, duplicate, replace,
// delete and sink registration up to a full sink table. Random phases under
// several own-node settings follow, mostly on a small node pool so the stream
// table fills up. Results are checked against typed rows or a local predictor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 308;

  typedef struct packed {
    logic [srt_pkg::MODE_W-1:0] mode;
    logic [srt_pkg::NODE_W-1:0] node;
    logic [srt_pkg::SID_W-1:0]  sid;
    logic [srt_pkg::TIME_W-1:0] ival;
    logic [srt_pkg::TIME_W-1:0] start;
  } request_t;

  typedef struct packed {
    logic [srt_pkg::STATUS_W-1:0] status;
    logic [srt_pkg::HELD_W-1:0]   held;
  } result_t;

  typedef struct packed {
    logic [srt_pkg::MODE_W-1:0]   mode;
    logic [srt_pkg::NODE_W-1:0]   node;
    logic [srt_pkg::SID_W-1:0]    sid;
    logic [srt_pkg::TIME_W-1:0]   ival;
    logic [srt_pkg::TIME_W-1:0]   start;
    logic                         typed;
    logic [srt_pkg::STATUS_W-1:0] status;
    logic [srt_pkg::HELD_W-1:0]   held;
  } plan_row_t;

  logic                         clk           = 1'b0;
  logic                         rst           = 1'b1;
  logic                         cfg_valid     = 1'b0;
  logic                         cfg_ready;
  logic [srt_pkg::NODE_W-1:0]   cfg_data      = '0;
  logic                         in_valid      = 1'b0;
  logic                         in_ready;
  logic [srt_pkg::MODE_W-1:0]   mode          = '0;
  logic [srt_pkg::NODE_W-1:0]   source_node   = '0;
  logic [srt_pkg::SID_W-1:0]    stream_number = '0;
  logic [srt_pkg::TIME_W-1:0]   interval      = '0;
  logic [srt_pkg::TIME_W-1:0]   start_time    = '0;
  logic                         out_valid;
  logic                         out_ready     = 1'b0;
  logic [srt_pkg::STATUS_W-1:0] status;
  logic [srt_pkg::HELD_W-1:0]   streams_held;

  stream_request_table_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .source_node  (source_node),
    .stream_number(stream_number),
    .interval     (interval),
    .start_time   (start_time),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .streams_held (streams_held)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state
  logic [srt_pkg::NODE_W-1:0] own_id = '0;
  logic                       slot_used [srt_pkg::MAX_STREAMS_DEF];
  srt_pkg::entry_t            slot_entry [srt_pkg::MAX_STREAMS_DEF];
  int                         stream_total = 0;
  logic                       sink_used [srt_pkg::MAX_SINKS_DEF];
  logic [srt_pkg::NODE_W-1:0] sink_id [srt_pkg::MAX_SINKS_DEF];

  result_t pending [$];
  result_t head_result;
  int      fails = 0;
  int      idle_cycles = 0;
  int      stall_left = 0;
  bit      tx_steady = 0;
  bit      rx_steady = 0;

  logic [srt_pkg::NODE_W-1:0] node_pool [8] = '{16'h0000, 16'h0001, 16'h0002, 16'h0003,
                                                16'h7FFF, 16'h8000, 16'hFFFE, 16'hFFFF};

  plan_row_t dir_plan [25] = '{
    '{srt_pkg::MODE_ADD, 16'h0000, 3'd0, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_IGNORED, 5'd0},
    '{srt_pkg::MODE_SINK, 16'h0000, 3'd0, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_IGNORED, 5'd0},
    '{srt_pkg::MODE_ADD, 16'h0001, 3'd3, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_IGNORED, 5'd0},
    '{srt_pkg::MODE_DELETE, 16'h0001, 3'd7, 16'hFFFF, 16'hFFFF,
      1'b1, srt_pkg::STAT_IGNORED, 5'd0},
    '{srt_pkg::MODE_ADD, 16'h0001, 3'd0, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_ADDED, 5'd1},
    '{srt_pkg::MODE_ADD, 16'h0001, 3'd0, 16'hFFFF, 16'hFFFF,
      1'b1, srt_pkg::STAT_DUPLICATE, 5'd1},
    '{srt_pkg::MODE_ADD, 16'hFFFF, 3'd2, 16'hFFFF, 16'h0000,
      1'b1, srt_pkg::STAT_ADDED, 5'd2},
    '{srt_pkg::MODE_ADD, 16'h0002, 3'd1, 16'h0000, 16'h1234,
      1'b1, srt_pkg::STAT_ADDED, 5'd3},
    '{srt_pkg::MODE_DELETE, 16'h0001, 3'd1, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_DEL_NOT_FOUND, 5'd3},
    '{srt_pkg::MODE_REPLACE, 16'h0001, 3'd0, 16'h8000, 16'h7FFF,
      1'b0, srt_pkg::STAT_IGNORED, 5'd0},
    '{srt_pkg::MODE_REPLACE, 16'h0003, 3'd0, 16'h5555, 16'hAAAA,
      1'b0, srt_pkg::STAT_IGNORED, 5'd0},
    '{srt_pkg::MODE_DELETE, 16'hFFFF, 3'd2, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_DELETED, 5'd3},
    '{srt_pkg::MODE_DELETE, 16'hFFFF, 3'd2, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_DEL_NOT_FOUND, 5'd3},
    '{srt_pkg::MODE_SINK, 16'h0005, 3'd0, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_SINK_ADDED, 5'd3},
    '{srt_pkg::MODE_SINK, 16'h0005, 3'd2, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_SINK_DUP, 5'd3},
    '{srt_pkg::MODE_SINK, 16'h0005, 3'd3, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_IGNORED, 5'd3},
    '{srt_pkg::MODE_SINK, 16'hFFFF, 3'd0, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_SINK_ADDED, 5'd3},
    '{srt_pkg::MODE_SINK, 16'h0001, 3'd1, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_SINK_ADDED, 5'd3},
    '{srt_pkg::MODE_SINK, 16'h0002, 3'd2, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_SINK_ADDED, 5'd3},
    '{srt_pkg::MODE_SINK, 16'h0003, 3'd0, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_SINK_ADDED, 5'd3},
    '{srt_pkg::MODE_SINK, 16'h0004, 3'd0, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_SINK_ADDED, 5'd3},
    '{srt_pkg::MODE_SINK, 16'h0006, 3'd0, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_SINK_ADDED, 5'd3},
    '{srt_pkg::MODE_SINK, 16'h0007, 3'd0, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_SINK_ADDED, 5'd3},
    '{srt_pkg::MODE_SINK, 16'h0008, 3'd0, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_SINK_FULL, 5'd3},
    '{srt_pkg::MODE_SINK, 16'hFFFF, 3'd1, 16'h0001, 16'h0000,
      1'b1, srt_pkg::STAT_SINK_DUP, 5'd3}
  };

  initial begin
    for (int i = 0; i < srt_pkg::MAX_STREAMS_DEF; i++) slot_used[i] = 1'b0;
    for (int i = 0; i < srt_pkg::MAX_SINKS_DEF; i++) sink_used[i] = 1'b0;
  end

  task automatic flag_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    fails++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
  endtask

  function automatic int find_stream(input logic [srt_pkg::NODE_W-1:0] node,
                                     input logic [srt_pkg::SID_W-1:0] sid);
    for (int i = 0; i < srt_pkg::MAX_STREAMS_DEF; i++) begin
      if (slot_used[i] && slot_entry[i].node == node && slot_entry[i].stream == sid) return i;
    end
    return -1;
  endfunction

  function automatic bit place_stream(input request_t r);
    for (int i = 0; i < srt_pkg::MAX_STREAMS_DEF; i++) begin
      if (!slot_used[i]) begin
        slot_used[i]             = 1'b1;
        slot_entry[i].node       = r.node;
        slot_entry[i].stream     = r.sid;
        slot_entry[i].interval   = r.ival;
        slot_entry[i].last_slot  = r.start - r.ival;
        slot_entry[i].ready_time = r.start;
        slot_entry[i].missed     = '0;
        stream_total++;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic result_t apply_request(input request_t r);
    result_t res;
    int      hit;
    int      free_sink;
    res.status = srt_pkg::STAT_IGNORED;
    if (r.sid <= srt_pkg::TOP_STREAM_ID && r.node != own_id) begin
      hit = find_stream(r.node, r.sid);
      case (r.mode)
        srt_pkg::MODE_ADD: begin
          if (hit >= 0) begin
            slot_entry[hit].missed = '0;
            res.status = srt_pkg::STAT_DUPLICATE;
          end else begin
            res.status = place_stream(r) ? srt_pkg::STAT_ADDED : srt_pkg::STAT_NO_SPACE;
          end
        end
        srt_pkg::MODE_REPLACE: begin
          if (hit >= 0) begin
            slot_used[hit] = 1'b0;
            stream_total--;
          end
          res.status = place_stream(r) ? srt_pkg::STAT_REPLACED :
                                         srt_pkg::STAT_REPLACED_NO_SPACE;
        end
        srt_pkg::MODE_DELETE: begin
          if (hit >= 0) begin
            slot_used[hit] = 1'b0;
            stream_total--;
            res.status = srt_pkg::STAT_DELETED;
          end else begin
            res.status = srt_pkg::STAT_DEL_NOT_FOUND;
          end
        end
        default: begin
          free_sink = -1;
          res.status = srt_pkg::STAT_SINK_ADDED;
          for (int i = 0; i < srt_pkg::MAX_SINKS_DEF; i++) begin
            if (sink_used[i]) begin
              if (sink_id[i] == r.node) res.status = srt_pkg::STAT_SINK_DUP;
            end else if (free_sink < 0) begin
              free_sink = i;
            end
          end
          if (res.status == srt_pkg::STAT_SINK_ADDED) begin
            if (free_sink < 0) begin
              res.status = srt_pkg::STAT_SINK_FULL;
            end else begin
              sink_used[free_sink] = 1'b1;
              sink_id[free_sink] = r.node;
            end
          end
        end
      endcase
    end
    res.held = srt_pkg::HELD_W'(stream_total);
    return res;
  endfunction

  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic request_t make_request();
    request_t r;
    int       pick;
    if ($urandom_range(0, 99) < 15) begin
      r.mode  = srt_pkg::MODE_W'($urandom);
      r.node  = srt_pkg::NODE_W'($urandom);
      r.sid   = srt_pkg::SID_W'($urandom);
      r.ival  = srt_pkg::TIME_W'($urandom);
      r.start = srt_pkg::TIME_W'($urandom);
      return r;
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) r.mode = srt_pkg::MODE_ADD;
    else if (pick < 60) r.mode = srt_pkg::MODE_REPLACE;
    else if (pick < 92) r.mode = srt_pkg::MODE_DELETE;
    else r.mode = srt_pkg::MODE_SINK;
    r.node = node_pool[$urandom_range(0, 7)];
    r.sid  = srt_pkg::SID_W'($urandom_range(0, 2));
    case ($urandom_range(0, 9))
      0: r.ival = 16'h0001;
      1: r.ival = 16'hFFFF;
      default: r.ival = srt_pkg::TIME_W'($urandom_range(1, 65535));
    endcase
    r.start = srt_pkg::TIME_W'($urandom);
    return r;
  endfunction

  // Entered at a clock edge; returns at the edge that accepts the write.
  task automatic write_own_id(input logic [srt_pkg::NODE_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    own_id = value;
  endtask

  // Entered at a clock edge; returns at the edge that accepts the request.
  task automatic send_request(input request_t r, input logic typed,
                              input logic [srt_pkg::STATUS_W-1:0] st,
                              input logic [srt_pkg::HELD_W-1:0] held);
    int      gap;
    result_t res;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= r.mode;
    source_node   <= r.node;
    stream_number <= r.sid;
    interval      <= r.ival;
    start_time    <= r.start;
    do @(posedge clk); while (!in_ready);
    res = apply_request(r);
    if (typed) begin
      res.status = st;
      res.held   = held;
    end
    pending.push_back(res);
  endtask

  task automatic settle(input int tail);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // Result side: random stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 3) == 0) stall_left = pick_gap(1'b0);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending.size() == 0) begin
        flag_mismatch("unexpected transaction, status", 16'(status), 16'd0);
      end else begin
        head_result = pending.pop_front();
        if (status !== head_result.status)
          flag_mismatch("status", 16'(status), 16'(head_result.status));
        if (streams_held !== head_result.held)
          flag_mismatch("streams_held", 16'(streams_held), 16'(head_result.held));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (cfg_valid && cfg_ready) ||
        (out_valid === 1'b1 && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    request_t                   rq;
    logic [srt_pkg::NODE_W-1:0] own_pick;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_own_id(16'h0000);
    foreach (dir_plan[i]) begin
      rq.mode  = dir_plan[i].mode;
      rq.node  = dir_plan[i].node;
      rq.sid   = dir_plan[i].sid;
      rq.ival  = dir_plan[i].ival;
      rq.start = dir_plan[i].start;
      send_request(rq, dir_plan[i].typed, dir_plan[i].status, dir_plan[i].held);
    end
    settle(4);
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: own_pick = 16'hFFFF;
        1: own_pick = node_pool[$urandom_range(0, 7)];
        2: own_pick = srt_pkg::NODE_W'($urandom);
        3: own_pick = 16'h0000;
        4: own_pick = node_pool[$urandom_range(0, 7)];
        default: own_pick = 16'hFFFF;
      endcase
      write_own_id(own_pick);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 64 == 0) begin
          tx_steady = ($urandom_range(0, 3) == 0);
          rx_steady = ($urandom_range(0, 3) == 0);
        end
        send_request(make_request(), 1'b0, srt_pkg::STAT_IGNORED, '0);
      end
      settle(phase == 5 ? 40 : 4);
    end
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
